@@ rtl/core/lsc_pkg.sv @@
// lsc_pkg: shared types, codes and the region-code function of the segment clipper
`timescale 1ns / 1ps
package lsc_pkg;

	// widest coordinate the region compare handles
	localparam int CMAX_W = 32;

	// region code bits
	localparam logic [3:0] CODE_LEFT   = 4'b0001;
	localparam logic [3:0] CODE_RIGHT  = 4'b0010;
	localparam logic [3:0] CODE_BOTTOM = 4'b0100;
	localparam logic [3:0] CODE_TOP    = 4'b1000;

	// configuration register indexes
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_BOTTOM = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	// integer part of the window edges after reset
	localparam int RST_EDGE_LO = 50;
	localparam int RST_EDGE_HI = 250;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_MUL,
		BK_DIV,
		BK_UPDATE,
		BK_DONE
	} back_state_t;

	// region code of one point against the window
	function automatic logic [3:0] region_code(
		input logic signed [CMAX_W-1:0] x,
		input logic signed [CMAX_W-1:0] y,
		input logic signed [CMAX_W-1:0] l,
		input logic signed [CMAX_W-1:0] r,
		input logic signed [CMAX_W-1:0] b,
		input logic signed [CMAX_W-1:0] t
	);
		logic [3:0] c;
		c = '0;
		if (x < l)
			c = c | CODE_LEFT;
		else if (x > r)
			c = c | CODE_RIGHT;
		if (y < b)
			c = c | CODE_BOTTOM;
		else if (y > t)
			c = c | CODE_TOP;
		return c;
	endfunction

endpackage

@@ rtl/core/line_segment_clipper.sv @@
// line_segment_clipper: top level of the segment clipper against a register-held window
//
//  channel  | ports                                   | word accepted when
//  ---------+-----------------------------------------+-----------------------
//  segment  | push full start_x start_y end_x end_y   | push && !full
//  result   | pop empty accepted clipped_*            | pop && !empty
//  config   | cfg_we cfg_index cfg_data               | cfg_we
//
// A segment passes a setup step and at most MAX_CLIP_STEPS clip moves, each a setup,
// a multiply, the bit-serial divide of the clipping engine and an update, and then goes
// to the result register once that is free.
// The two-word queue takes new segments while the engine works or the result waits.
// Reset restores the default window and empties queue and result register.
`timescale 1ns / 1ps
module line_segment_clipper #(
	parameter int COORD_WIDTH    = 24,
	parameter int FRACTION_BITS  = 8,
	parameter int MAX_CLIP_STEPS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic                          pop,
	output logic                          empty,
	output logic                          accepted,
	output logic signed [COORD_WIDTH-1:0] clipped_start_x,
	output logic signed [COORD_WIDTH-1:0] clipped_start_y,
	output logic signed [COORD_WIDTH-1:0] clipped_end_x,
	output logic signed [COORD_WIDTH-1:0] clipped_end_y,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);
	import lsc_pkg::*;

	localparam int QW = 4 * COORD_WIDTH + 8;
	localparam logic [COORD_WIDTH-1:0] EDGE_LO = COORD_WIDTH'(RST_EDGE_LO << FRACTION_BITS);
	localparam logic [COORD_WIDTH-1:0] EDGE_HI = COORD_WIDTH'(RST_EDGE_HI << FRACTION_BITS);

	logic signed [COORD_WIDTH-1:0] win_l_q, win_r_q, win_b_q, win_t_q;
	logic [QW-1:0] f_word;
	logic [QW-1:0] q_word;
	logic          q_valid;
	logic          q_pop;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q <= EDGE_LO;
			win_r_q <= EDGE_HI;
			win_b_q <= EDGE_LO;
			win_t_q <= EDGE_HI;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   win_l_q <= cfg_data;
				REG_RIGHT:  win_r_q <= cfg_data;
				REG_BOTTOM: win_b_q <= cfg_data;
				REG_TOP:    win_t_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lsc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.win_l(win_l_q), .win_r(win_r_q), .win_b(win_b_q), .win_t(win_t_q),
		.word(f_word)
	);

	lsc_queue #(.DATA_W(QW), .DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push), .wr_data(f_word), .full(full),
		.rd_en(q_pop), .valid(q_valid), .rd_data(q_word)
	);

	lsc_back #(.COORD_WIDTH(COORD_WIDTH), .MAX_CLIP_STEPS(MAX_CLIP_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.win_l(win_l_q), .win_r(win_r_q), .win_b(win_b_q), .win_t(win_t_q),
		.q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
		.pop(pop), .empty(empty), .accepted(accepted),
		.clipped_start_x(clipped_start_x), .clipped_start_y(clipped_start_y),
		.clipped_end_x(clipped_end_x), .clipped_end_y(clipped_end_y)
	);

endmodule

@@ rtl/core/lsc_front.sv @@
// lsc_front: region coding of both endpoints and packing of the queue word
`timescale 1ns / 1ps
module lsc_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] win_l,
	input  logic signed [COORD_WIDTH-1:0] win_r,
	input  logic signed [COORD_WIDTH-1:0] win_b,
	input  logic signed [COORD_WIDTH-1:0] win_t,
	output logic [4*COORD_WIDTH+7:0]      word
);
	import lsc_pkg::*;

	logic [3:0] c1;
	logic [3:0] c2;

	// classify both endpoints
	always_comb begin
		c1 = region_code(CMAX_W'(start_x), CMAX_W'(start_y), CMAX_W'(win_l),
			CMAX_W'(win_r), CMAX_W'(win_b), CMAX_W'(win_t));
		c2 = region_code(CMAX_W'(end_x), CMAX_W'(end_y), CMAX_W'(win_l),
			CMAX_W'(win_r), CMAX_W'(win_b), CMAX_W'(win_t));
	end

	assign word = {c2, c1, end_y, end_x, start_y, start_x};

endmodule

@@ rtl/core/lsc_queue.sv @@
// lsc_queue: short register queue between the front and the clipping engine
`timescale 1ns / 1ps
module lsc_queue #(
	parameter int DATA_W = 104,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              valid,
	output logic [DATA_W-1:0] rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == NW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/core/lsc_back.sv @@
// lsc_back: clipping engine with a shared multiplier, bit-serial divider and result register
`timescale 1ns / 1ps
module lsc_back #(
	parameter int COORD_WIDTH    = 24,
	parameter int MAX_CLIP_STEPS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [COORD_WIDTH-1:0] win_l,
	input  logic signed [COORD_WIDTH-1:0] win_r,
	input  logic signed [COORD_WIDTH-1:0] win_b,
	input  logic signed [COORD_WIDTH-1:0] win_t,
	input  logic                          q_valid,
	input  logic [4*COORD_WIDTH+7:0]      q_word,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic                          accepted,
	output logic signed [COORD_WIDTH-1:0] clipped_start_x,
	output logic signed [COORD_WIDTH-1:0] clipped_start_y,
	output logic signed [COORD_WIDTH-1:0] clipped_end_x,
	output logic signed [COORD_WIDTH-1:0] clipped_end_y
);
	import lsc_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int CW = $clog2(2 * W);
	localparam int SW = $clog2(MAX_CLIP_STEPS + 1);

	back_state_t state_q, state_d;

	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [3:0]          c1_q, c2_q;
	logic [SW-1:0]       step_q;

	// operands of one clip move
	logic signed [W-1:0] p_q, fix_q;
	logic [W-1:0]        a_q, b_q, den_q;
	logic                neg_q, fix_y_q, upd_start_q;

	logic [2*W-1:0]      div_q;
	logic [W-1:0]        rem_q;
	logic [CW-1:0]       cnt_q;

	logic                out_valid_q;
	logic                out_free;
	logic                out_load;
	logic                finish;

	// setup terms
	logic [3:0]            co;
	logic signed [W:0]     dp, num, den;
	logic signed [W-1:0]   p_sel, fix_sel;
	logic                  fix_y_sel;
	logic [W:0]            dp_m, num_m, den_m;

	// divider step
	logic [W:0]            rem_sh;
	logic                  q_bit;

	// update terms
	logic [2*W-1:0]        qv;
	logic signed [2*W+1:0] sum;
	logic                  fits;
	logic signed [W-1:0]   res;
	logic signed [W-1:0]   nx, ny;
	logic [3:0]            nc;

	assign out_free = !out_valid_q || pop;
	assign finish = ((c1_q == '0) && (c2_q == '0)) || ((c1_q & c2_q) != '0)
		|| (step_q == SW'(MAX_CLIP_STEPS));

	// edge choice for the outside endpoint, priority top, bottom, right, left
	always_comb begin
		co = (c1_q != '0) ? c1_q : c2_q;
		if ((co & CODE_TOP) != '0) begin
			p_sel = x1_q; fix_sel = win_t; fix_y_sel = 1'b1;
			dp = (W+1)'(x2_q) - (W+1)'(x1_q);
			num = (W+1)'(win_t) - (W+1)'(y1_q);
			den = (W+1)'(y2_q) - (W+1)'(y1_q);
		end else if ((co & CODE_BOTTOM) != '0) begin
			p_sel = x1_q; fix_sel = win_b; fix_y_sel = 1'b1;
			dp = (W+1)'(x2_q) - (W+1)'(x1_q);
			num = (W+1)'(win_b) - (W+1)'(y1_q);
			den = (W+1)'(y2_q) - (W+1)'(y1_q);
		end else if ((co & CODE_RIGHT) != '0) begin
			p_sel = y1_q; fix_sel = win_r; fix_y_sel = 1'b0;
			dp = (W+1)'(y2_q) - (W+1)'(y1_q);
			num = (W+1)'(win_r) - (W+1)'(x1_q);
			den = (W+1)'(x2_q) - (W+1)'(x1_q);
		end else begin
			p_sel = y1_q; fix_sel = win_l; fix_y_sel = 1'b0;
			dp = (W+1)'(y2_q) - (W+1)'(y1_q);
			num = (W+1)'(win_l) - (W+1)'(x1_q);
			den = (W+1)'(x2_q) - (W+1)'(x1_q);
		end
		dp_m  = dp[W]  ? (W+1)'(-dp)  : (W+1)'(dp);
		num_m = num[W] ? (W+1)'(-num) : (W+1)'(num);
		den_m = den[W] ? (W+1)'(-den) : (W+1)'(den);
	end

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q, div_q[2*W-1]};
		q_bit  = (rem_sh >= {1'b0, den_q});
	end

	// apply the quotient, saturate and recode the moved point
	always_comb begin
		qv  = (den_q == '0) ? '0 : div_q;
		sum = neg_q ? (2*W+2)'(p_q) - signed'({2'b00, qv})
			: (2*W+2)'(p_q) + signed'({2'b00, qv});
		fits = (sum[2*W+1:W-1] == '0) || (sum[2*W+1:W-1] == '1);
		if (fits)
			res = sum[W-1:0];
		else
			res = sum[2*W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		nx = fix_y_q ? res : fix_q;
		ny = fix_y_q ? fix_q : res;
		nc = region_code(CMAX_W'(nx), CMAX_W'(ny), CMAX_W'(win_l),
			CMAX_W'(win_r), CMAX_W'(win_b), CMAX_W'(win_t));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (q_valid) state_d = BK_SETUP;
			BK_SETUP:  state_d = finish ? BK_DONE : BK_MUL;
			BK_MUL:    state_d = BK_DIV;
			BK_DIV:    if (cnt_q == CW'(2 * W - 1)) state_d = BK_UPDATE;
			BK_UPDATE: state_d = BK_SETUP;
			BK_DONE:   if (out_free) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop    = (state_q == BK_IDLE) && q_valid;
		out_load = (state_q == BK_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// segment, operands and divider
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					{c2_q, c1_q, y2_q, x2_q, y1_q, x1_q} <= q_word;
					step_q <= '0;
				end
			end
			BK_SETUP: begin
				p_q         <= p_sel;
				fix_q       <= fix_sel;
				fix_y_q     <= fix_y_sel;
				a_q         <= dp_m[W-1:0];
				b_q         <= num_m[W-1:0];
				den_q       <= den_m[W-1:0];
				neg_q       <= dp[W] ^ num[W] ^ den[W];
				upd_start_q <= (c1_q != '0);
			end
			BK_MUL: begin
				div_q <= (2*W)'(a_q) * (2*W)'(b_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= q_bit ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
				div_q <= {div_q[2*W-2:0], q_bit};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_UPDATE: begin
				if (upd_start_q) begin
					x1_q <= nx; y1_q <= ny; c1_q <= nc;
				end else begin
					x2_q <= nx; y2_q <= ny; c2_q <= nc;
				end
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if ((c1_q == '0) && (c2_q == '0)) begin
				accepted        <= 1'b1;
				clipped_start_x <= x1_q;
				clipped_start_y <= y1_q;
				clipped_end_x   <= x2_q;
				clipped_end_y   <= y2_q;
			end else begin
				accepted        <= 1'b0;
				clipped_start_x <= '0;
				clipped_start_y <= '0;
				clipped_end_x   <= '0;
				clipped_end_y   <= '0;
			end
		end
	end

	assign empty = !out_valid_q;

endmodule

@@ rtl/core/lsc_checker.sv @@
// lsc_checker: port-level assertions of the segment clipper and their bind
`timescale 1ns / 1ps
module lsc_checker #(
	parameter int COORD_WIDTH = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   full,
	input logic                   pop,
	input logic                   empty,
	input logic                   accepted,
	input logic [COORD_WIDTH-1:0] clipped_start_x,
	input logic [COORD_WIDTH-1:0] clipped_start_y,
	input logic [COORD_WIDTH-1:0] clipped_end_x,
	input logic [COORD_WIDTH-1:0] clipped_end_y
);

	// a rejected result carries zero endpoints
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !accepted) |-> (clipped_start_x == '0 && clipped_start_y == '0
			&& clipped_end_x == '0 && clipped_end_y == '0))
		else $error("rejected result with nonzero endpoints");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(accepted) && $stable(clipped_start_x)
			&& $stable(clipped_start_y) && $stable(clipped_end_x)
			&& $stable(clipped_end_y)))
		else $error("waiting result changed");

	// first cycle out of reset: queue has room and no result waits
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("queue or result not cleared by reset");

	// handshake flags are always known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}))
		else $error("unknown full or empty");

endmodule

bind line_segment_clipper lsc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lsc_checker (
	.clk(clk), .arst_n(arst_n), .full(full), .pop(pop), .empty(empty),
	.accepted(accepted), .clipped_start_x(clipped_start_x),
	.clipped_start_y(clipped_start_y), .clipped_end_x(clipped_end_x),
	.clipped_end_y(clipped_end_y)
);
